// ===== rtl/core/cpcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpcm_pkg: shared types and constants
// Field widths, radius limits and the pixel request record used by the
// circular patch centroid moments unit.
// ----------------------------------------------------------------------------
package cpcm_pkg;

    localparam int OFFSET_W   = 8;
    localparam int PIXEL_W    = 8;
    localparam int RADIUS_W   = 7;
    localparam int MOMENT_W   = 27;
    localparam int PRODUCT_W  = OFFSET_W + PIXEL_W;
    localparam int SQUARE_W   = 2 * OFFSET_W;
    localparam int DIST_W     = SQUARE_W + 1;

    localparam logic [RADIUS_W-1:0] MAX_RADIUS   = RADIUS_W'(64);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(15);

    typedef logic signed [OFFSET_W-1:0]  offset_t;
    typedef logic        [PIXEL_W-1:0]   pixel_t;
    typedef logic        [RADIUS_W-1:0]  radius_t;
    typedef logic signed [MOMENT_W-1:0]  moment_t;

    typedef struct packed {
        offset_t col_offset;
        offset_t row_offset;
        pixel_t  pixel;
        logic    in_image;
        logic    last;
    } pix_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpcm_pixel_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpcm_pixel_if: pixel request channel
// Valid/ready channel carrying one patch pixel with its offsets and flags.
// ----------------------------------------------------------------------------
interface cpcm_pixel_if
    import cpcm_pkg::*;
;
    logic    valid;
    logic    ready;
    offset_t col_offset;
    offset_t row_offset;
    pixel_t  pixel;
    logic    in_image;
    logic    last;

    modport source (
        output valid,
        output col_offset,
        output row_offset,
        output pixel,
        output in_image,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  col_offset,
        input  row_offset,
        input  pixel,
        input  in_image,
        input  last,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/cpcm_moment_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpcm_moment_if: moment result channel
// Valid/ready channel carrying the two first-order moments of one patch.
// ----------------------------------------------------------------------------
interface cpcm_moment_if
    import cpcm_pkg::*;
;
    logic    valid;
    logic    ready;
    moment_t moment_01;
    moment_t moment_10;

    modport source (
        output valid,
        output moment_01,
        output moment_10,
        input  ready
    );

    modport sink (
        input  valid,
        input  moment_01,
        input  moment_10,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/circular_patch_centroid_moments_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_patch_centroid_moments_unit: top level
// Intensity-centroid moments of a circular keypoint patch.
// ----------------------------------------------------------------------------
// The unit takes one pixel request per cycle. A request passes an input
// register, then the disk test and the two offset-times-intensity products
// feed the running sums in the next cycle; the request flagged last loads
// the result register when the accumulator takes it from the input
// register. The only stall comes from the result register: while a result
// waits to be taken, a further last request holds in the input register and
// backs up the channel; other requests keep flowing at one per cycle.
// Radius writes saturate at MAX_RADIUS and should be issued while idle.
// ----------------------------------------------------------------------------
module circular_patch_centroid_moments_unit
    import cpcm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr_en,
    input  wire radius_t cfg_wr_data,
    cpcm_pixel_if.sink   pix_in,
    cpcm_moment_if.source mom_out
);

    radius_t  radius_reg;
    radius_t  radius_next;
    pix_req_t in_req;
    pix_req_t req;
    logic     req_valid;
    logic     req_take;

    assign radius_next = (cfg_wr_data > MAX_RADIUS) ? MAX_RADIUS : cfg_wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            radius_reg <= radius_next;
        end
    end

    assign in_req.col_offset = pix_in.col_offset;
    assign in_req.row_offset = pix_in.row_offset;
    assign in_req.pixel      = pix_in.pixel;
    assign in_req.in_image   = pix_in.in_image;
    assign in_req.last       = pix_in.last;

    cpcm_input_stage u_input_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .in_req    (in_req),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req)
    );

    cpcm_moment_acc u_moment_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (radius_reg),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req),
        .out_valid (mom_out.valid),
        .out_ready (mom_out.ready),
        .moment_01 (mom_out.moment_01),
        .moment_10 (mom_out.moment_10)
    );

endmodule
`default_nettype wire

// ===== rtl/core/cpcm_input_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpcm_input_stage: pixel request register
// Captures one accepted pixel request and holds it until the moment
// accumulator takes it.
// ----------------------------------------------------------------------------
module cpcm_input_stage
    import cpcm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire pix_req_t in_req,
    output logic          req_valid,
    input  wire logic     req_take,
    output pix_req_t      req
);

    logic     valid_reg;
    logic     valid_next;
    pix_req_t req_reg;

    assign in_ready   = !valid_reg || req_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !req_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule
`default_nettype wire

// ===== rtl/core/cpcm_moment_acc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpcm_moment_acc: disk test and moment accumulator
// Tests the pixel against the disk, adds its weighted offsets to the two
// running sums and loads the result register on the last pixel of a patch.
// ----------------------------------------------------------------------------
module cpcm_moment_acc
    import cpcm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire radius_t  radius,
    input  wire logic     req_valid,
    output logic          req_take,
    input  wire pix_req_t req,
    output logic          out_valid,
    input  wire logic     out_ready,
    output moment_t       moment_01,
    output moment_t       moment_10
);

    logic signed [SQUARE_W-1:0]  col_sq;
    logic signed [SQUARE_W-1:0]  row_sq;
    logic        [DIST_W-1:0]    dist_sq;
    logic        [DIST_W-1:0]    radius_sq;
    logic                        hit;
    logic signed [PIXEL_W:0]     pixel_s;
    logic signed [PRODUCT_W:0]   row_prod;
    logic signed [PRODUCT_W:0]   col_prod;
    moment_t                     row_add;
    moment_t                     col_add;
    moment_t                     row_sum_reg;
    moment_t                     col_sum_reg;
    moment_t                     row_sum_next;
    moment_t                     col_sum_next;
    logic                        out_valid_reg;
    moment_t                     out_01_reg;
    moment_t                     out_10_reg;

    assign col_sq    = SQUARE_W'(req.col_offset * req.col_offset);
    assign row_sq    = SQUARE_W'(req.row_offset * req.row_offset);
    assign dist_sq   = {1'b0, col_sq} + {1'b0, row_sq};
    assign radius_sq = DIST_W'(radius * radius);
    assign hit       = req.in_image && (dist_sq <= radius_sq);

    assign pixel_s  = $signed({1'b0, req.pixel});
    assign row_prod = (PRODUCT_W + 1)'(req.row_offset * pixel_s);
    assign col_prod = (PRODUCT_W + 1)'(req.col_offset * pixel_s);
    assign row_add  = hit ? MOMENT_W'(row_prod) : '0;
    assign col_add  = hit ? MOMENT_W'(col_prod) : '0;

    assign row_sum_next = row_sum_reg + row_add;
    assign col_sum_next = col_sum_reg + col_add;

    assign req_take = req_valid && (!req.last || !out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg   <= '0;
            col_sum_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
            begin
                if (req.last)
                begin
                    row_sum_reg <= '0;
                    col_sum_reg <= '0;
                end
                else
                begin
                    row_sum_reg <= row_sum_next;
                    col_sum_reg <= col_sum_next;
                end
            end
            if (req_take && req.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && req.last)
        begin
            out_01_reg <= row_sum_next;
            out_10_reg <= col_sum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign moment_01 = out_01_reg;
    assign moment_10 = out_10_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.last |=> row_sum_reg == '0 && col_sum_reg == '0)
        else $error("sums not cleared after last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.last |=> out_valid_reg)
        else $error("result not loaded after last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_take && !req.last && !hit |=> $stable(row_sum_reg) && $stable(col_sum_reg))
        else $error("sums changed on pixel outside the disk");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req.last && out_valid_reg && !out_ready |-> !req_take)
        else $error("last pixel taken over a pending result");
`endif

endmodule
`default_nettype wire
